@@ hdl/swr_pkg.sv @@
// ----------------------------------------------------------------------------
// swr_pkg: shared types and constants of the sync word deframer and router
// Holds the frame constants, the result word type and the burst group type
// passed from the frame tracker to the output buffer.
// ----------------------------------------------------------------------------
package swr_pkg;

    localparam logic [15:0] SYNC_WORD       = 16'hFEED;
    localparam logic [15:0] BUTTON_PROTOCOL = 16'd8;
    localparam logic [11:0] MAX_LEN_RESET   = 12'd2048;
    localparam logic [11:0] FOOTER_BYTES    = 12'd2;

    // Largest number of result words one input word can cause
    localparam int BURST_LEN = 6;
    // Output buffer depth: one full group behind one waiting word
    localparam int BUF_LEN   = BURST_LEN + 1;
    localparam int CNT_W     = $clog2(BUF_LEN + 1);

    localparam logic KIND_FWD    = 1'b0;
    localparam logic KIND_BUTTON = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [7:0] data;
        logic       last;
    } t_result;

    typedef struct packed {
        logic [CNT_W-1:0]           cnt;
        t_result [BURST_LEN-1:0]    items;
    } t_burst;

endpackage

@@ hdl/sync_word_packet_deframer_router.sv @@
// ----------------------------------------------------------------------------
// sync_word_packet_deframer_router: sync word deframer and router
// Output: a result word is registered in the output buffer before it shows.
// Throughput: one input word per cycle while o_ready; a header replay emits
//   six result words and drops o_ready until one word at most is left.
// Reset: synchronous, active low; hunts for sync, limit back to 2048.
// ----------------------------------------------------------------------------
module sync_word_packet_deframer_router (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_in_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_out_kind,
    output logic [7:0]  o_out_byte,
    output logic        o_last_of_run,
    input  logic        i_cfg_we,
    input  logic [11:0] i_cfg_data
);

    logic [11:0]      r_max_len;
    logic             accept;
    swr_pkg::t_burst  burst;
    swr_pkg::t_result head;

    assign accept = i_valid && o_ready;

    // Hold the payload length limit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= swr_pkg::MAX_LEN_RESET;
        end else if (i_cfg_we) begin
            r_max_len <= i_cfg_data;
        end
    end

    swr_frame u_frame (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_in_byte (i_in_byte),
        .i_max_len (r_max_len),
        .o_burst   (burst)
    );

    swr_outbuf u_outbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (accept),
        .i_burst (burst),
        .i_ready (i_ready),
        .o_valid (o_valid),
        .o_head  (head),
        .o_room  (o_ready)
    );

    assign o_out_kind    = head.kind;
    assign o_out_byte    = head.data;
    assign o_last_of_run = head.last;

endmodule

@@ hdl/swr_frame.sv @@
// ----------------------------------------------------------------------------
// swr_frame: frame tracker
// Walks sync, protocol, length, payload and footer one word at a time and
// forms the group of result words that each accepted word causes.
// ----------------------------------------------------------------------------
module swr_frame (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic [7:0]         i_in_byte,
    input  logic [11:0]        i_max_len,
    output swr_pkg::t_burst    o_burst
);

    typedef enum logic [2:0] {
        PH_SYNC_HI,
        PH_SYNC_LO,
        PH_PROTO_HI,
        PH_PROTO_LO,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_PAYLOAD,
        PH_FOOTER
    } t_phase;

    t_phase      r_phase,   n_phase;
    logic [7:0]  r_held,    n_held;
    logic [15:0] r_proto,   n_proto;
    logic [11:0] r_len,     n_len;
    logic [11:0] r_remain,  n_remain;
    logic [7:0]  r_button,  n_button;

    logic        is_button;
    logic [15:0] word;
    logic        remain_last;

    assign is_button   = (r_proto == swr_pkg::BUTTON_PROTOCOL);
    assign word        = {r_held, i_in_byte};
    assign remain_last = (r_remain <= 12'd1);

    // Advance the frame phase and build the result group
    always_comb begin
        n_phase  = r_phase;
        n_held   = r_held;
        n_proto  = r_proto;
        n_len    = r_len;
        n_remain = r_remain;
        n_button = r_button;
        o_burst  = '0;
        if (i_accept) begin
            case (r_phase)
                PH_SYNC_HI: begin
                    n_held  = i_in_byte;
                    n_phase = PH_SYNC_LO;
                end
                PH_SYNC_LO: begin
                    // drop both words on a bad sync pair
                    n_phase = (word == swr_pkg::SYNC_WORD) ? PH_PROTO_HI : PH_SYNC_HI;
                end
                PH_PROTO_HI: begin
                    n_held  = i_in_byte;
                    n_phase = PH_PROTO_LO;
                end
                PH_PROTO_LO: begin
                    n_proto = word;
                    n_phase = PH_LEN_HI;
                end
                PH_LEN_HI: begin
                    n_held  = i_in_byte;
                    n_phase = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    if (word > {4'd0, i_max_len}) begin
                        // drop the whole header and hunt again
                        n_phase = PH_SYNC_HI;
                    end else begin
                        n_len = word[11:0];
                        if (!is_button) begin
                            // replay the header as one burst
                            o_burst.cnt      = swr_pkg::CNT_W'(swr_pkg::BURST_LEN);
                            o_burst.items[0] = '{swr_pkg::KIND_FWD,
                                                 swr_pkg::SYNC_WORD[15:8], 1'b0};
                            o_burst.items[1] = '{swr_pkg::KIND_FWD,
                                                 swr_pkg::SYNC_WORD[7:0], 1'b0};
                            o_burst.items[2] = '{swr_pkg::KIND_FWD, r_proto[15:8], 1'b0};
                            o_burst.items[3] = '{swr_pkg::KIND_FWD, r_proto[7:0], 1'b0};
                            o_burst.items[4] = '{swr_pkg::KIND_FWD, r_held, 1'b0};
                            o_burst.items[5] = '{swr_pkg::KIND_FWD, i_in_byte, 1'b1};
                        end
                        if (word[11:0] == 12'd0) begin
                            n_remain = swr_pkg::FOOTER_BYTES;
                            n_phase  = PH_FOOTER;
                        end else begin
                            n_remain = word[11:0];
                            n_phase  = PH_PAYLOAD;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    if (is_button) begin
                        n_button = i_in_byte;
                    end else begin
                        o_burst.cnt      = swr_pkg::CNT_W'(1);
                        o_burst.items[0] = '{swr_pkg::KIND_FWD, i_in_byte, 1'b1};
                    end
                    if (remain_last) begin
                        n_remain = swr_pkg::FOOTER_BYTES;
                        n_phase  = PH_FOOTER;
                    end else begin
                        n_remain = r_remain - 12'd1;
                    end
                end
                PH_FOOTER: begin
                    if (!is_button) begin
                        o_burst.cnt      = swr_pkg::CNT_W'(1);
                        o_burst.items[0] = '{swr_pkg::KIND_FWD, i_in_byte, 1'b1};
                    end
                    if (remain_last) begin
                        n_remain = 12'd0;
                        n_phase  = PH_SYNC_HI;
                        // report the button state once the footer completes, if the payload was one byte
                        if (is_button && r_len == 12'd1) begin
                            o_burst.cnt      = swr_pkg::CNT_W'(1);
                            o_burst.items[0] = '{swr_pkg::KIND_BUTTON, r_button, 1'b1};
                        end
                    end else begin
                        n_remain = r_remain - 12'd1;
                    end
                end
                default: begin
                    n_phase = PH_SYNC_HI;
                end
            endcase
        end
    end

    // Hold frame state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_SYNC_HI;
            r_held   <= '0;
            r_proto  <= '0;
            r_len    <= '0;
            r_remain <= '0;
            r_button <= '0;
        end else begin
            r_phase  <= n_phase;
            r_held   <= n_held;
            r_proto  <= n_proto;
            r_len    <= n_len;
            r_remain <= n_remain;
            r_button <= n_button;
        end
    end

endmodule

@@ hdl/swr_outbuf.sv @@
// ----------------------------------------------------------------------------
// swr_outbuf: result buffer
// Holds the result words of one input word and shifts them out one per
// accepted output handshake. Takes a new group while at most one word waits.
// ----------------------------------------------------------------------------
module swr_outbuf (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  swr_pkg::t_burst    i_burst,
    input  logic               i_ready,
    output logic               o_valid,
    output swr_pkg::t_result   o_head,
    output logic               o_room
);

    swr_pkg::t_result [swr_pkg::BUF_LEN-1:0] r_item, n_item, kept_item;
    logic [swr_pkg::CNT_W-1:0]               r_cnt,  n_cnt,  kept_cnt;
    logic                                    pop;

    assign o_valid = (r_cnt != '0);
    assign o_head  = r_item[0];
    assign pop     = o_valid && i_ready;
    // room for a new group behind at most one waiting word
    assign o_room  = (r_cnt <= swr_pkg::CNT_W'(1));

    // Advance the queue, then append a new group behind what is left
    always_comb begin
        kept_item = r_item;
        kept_cnt  = r_cnt;
        if (pop) begin
            for (int k = 0; k < swr_pkg::BUF_LEN - 1; k++) begin
                kept_item[k] = r_item[k + 1];
            end
            kept_item[swr_pkg::BUF_LEN-1] = '0;
            kept_cnt = r_cnt - swr_pkg::CNT_W'(1);
        end
        n_item = kept_item;
        n_cnt  = kept_cnt;
        if (i_load) begin
            if (kept_cnt == '0) begin
                n_item[swr_pkg::BURST_LEN-1:0] = i_burst.items;
            end else begin
                n_item[swr_pkg::BUF_LEN-1:1] = i_burst.items;
            end
            n_cnt = kept_cnt + i_burst.cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
    end

endmodule

@@ hdl/swr_checker.sv @@
// ----------------------------------------------------------------------------
// swr_checker: port-level checks of the deframer and router
// Watches the handshakes and the shape of result runs.
// ----------------------------------------------------------------------------
module swr_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_ready,
    input logic       o_valid,
    input logic       i_ready,
    input logic       o_out_kind,
    input logic [7:0] o_out_byte,
    input logic       o_last_of_run
);

    // Hold a stalled result word
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_out_byte) && $stable(o_out_kind)
            && $stable(o_last_of_run))
        else $error("stalled result word changed");

    // Take input only when at most the last word of a run waits
    a_ready_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> !o_valid || o_last_of_run)
        else $error("input taken while a run is pending");

    // A button state stands alone
    a_button_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out_kind |-> o_last_of_run)
        else $error("button state not last of its run");

    // A run continues without a gap
    a_run_gapless: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_last_of_run |=> o_valid && !o_out_kind)
        else $error("run broken before its last word");

endmodule

bind sync_word_packet_deframer_router swr_checker u_swr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_ready       (o_ready),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_out_kind    (o_out_kind),
    .o_out_byte    (o_out_byte),
    .o_last_of_run (o_last_of_run)
);

@@ bench/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the sync word deframer and router
// Streams host bytes through the deframer with random gaps on both sides,
// predicts every forwarded byte and button state from a local frame tracker,
// and compares each result word field by field in arrival order.
// ----------------------------------------------------------------------------
module testbench;

    // Frame tracker phases, in the order the header arrives
    typedef enum logic [2:0] {
        PH_SYNC_HI,
        PH_SYNC_LO,
        PH_PROTO_HI,
        PH_PROTO_LO,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_PAYLOAD,
        PH_FOOTER
    } t_frame_phase;

    localparam int CLK_HALF    = 4;
    localparam int DRAIN_LIMIT = 20000;
    localparam int SETTLE_CYC  = 4;
    localparam int PHASE_WORDS = 65;
    localparam int WORD_GAP    = 16;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_valid    = 1'b0;
    logic [7:0]  i_in_byte  = 8'h00;
    logic        i_ready    = 1'b0;
    logic        i_cfg_we   = 1'b0;
    logic [11:0] i_cfg_data = 12'd0;
    logic        o_ready;
    logic        o_valid;
    logic        o_out_kind;
    logic [7:0]  o_out_byte;
    logic        o_last_of_run;

    // Frame tracker state and its copy of the length limit
    t_frame_phase trk_phase;
    logic [7:0]   trk_hold;
    logic [15:0]  trk_proto;
    logic [11:0]  trk_len;
    logic [11:0]  trk_left;
    logic [7:0]   trk_button;
    logic [11:0]  trk_limit;

    // Result words owed by the block, oldest first
    swr_pkg::t_result out_words_due [$];

    int  n_fail          = 0;
    int  n_in_words      = 0;
    int  n_out_words     = 0;
    int  n_button_states = 0;
    int  n_limits        = 0;
    bit  tx_steady       = 1'b0;
    bit  rx_steady       = 1'b0;

    sync_word_packet_deframer_router dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_in_byte     (i_in_byte),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_out_kind    (o_out_kind),
        .o_out_byte    (o_out_byte),
        .o_last_of_run (o_last_of_run),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data)
    );

    // Clock: period 8
    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // Queue one owed result word
    function automatic void due_word(input logic kind, input logic [7:0] data,
                                     input logic last);
        swr_pkg::t_result w;
        w.kind = kind;
        w.data = data;
        w.last = last;
        out_words_due.push_back(w);
    endfunction

    // Advance the frame tracker by one accepted byte and queue what it causes
    function automatic void track_frame_byte(input logic [7:0] b);
        logic [15:0] word;
        logic        is_button;
        word      = {trk_hold, b};
        is_button = (trk_proto == swr_pkg::BUTTON_PROTOCOL);
        case (trk_phase)
            PH_SYNC_HI, PH_PROTO_HI, PH_LEN_HI: begin
                trk_hold  = b;
                trk_phase = t_frame_phase'(trk_phase + 3'd1);
            end
            PH_SYNC_LO: begin
                // drop a bad pair and hunt again
                trk_phase = (word == swr_pkg::SYNC_WORD) ? PH_PROTO_HI : PH_SYNC_HI;
            end
            PH_PROTO_LO: begin
                trk_proto = word;
                trk_phase = PH_LEN_HI;
            end
            PH_LEN_LO: begin
                if (word > {4'd0, trk_limit}) begin
                    // drop the whole header
                    trk_phase = PH_SYNC_HI;
                end else begin
                    trk_len = word[11:0];
                    if (!is_button) begin
                        due_word(swr_pkg::KIND_FWD, swr_pkg::SYNC_WORD[15:8], 1'b0);
                        due_word(swr_pkg::KIND_FWD, swr_pkg::SYNC_WORD[7:0], 1'b0);
                        due_word(swr_pkg::KIND_FWD, trk_proto[15:8], 1'b0);
                        due_word(swr_pkg::KIND_FWD, trk_proto[7:0], 1'b0);
                        due_word(swr_pkg::KIND_FWD, trk_hold, 1'b0);
                        due_word(swr_pkg::KIND_FWD, b, 1'b1);
                    end
                    if (trk_len == 12'd0) begin
                        trk_left  = swr_pkg::FOOTER_BYTES;
                        trk_phase = PH_FOOTER;
                    end else begin
                        trk_left  = trk_len;
                        trk_phase = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD: begin
                if (is_button) begin
                    trk_button = b;
                end else begin
                    due_word(swr_pkg::KIND_FWD, b, 1'b1);
                end
                if (trk_left <= 12'd1) begin
                    trk_left  = swr_pkg::FOOTER_BYTES;
                    trk_phase = PH_FOOTER;
                end else begin
                    trk_left = trk_left - 12'd1;
                end
            end
            default: begin
                if (!is_button) begin
                    due_word(swr_pkg::KIND_FWD, b, 1'b1);
                end
                if (trk_left <= 12'd1) begin
                    trk_left  = 12'd0;
                    trk_phase = PH_SYNC_HI;
                    if (is_button && trk_len == 12'd1) begin
                        due_word(swr_pkg::KIND_BUTTON, trk_button, 1'b1);
                    end
                end else begin
                    trk_left = trk_left - 12'd1;
                end
            end
        endcase
    endfunction

    // Send one byte: idle for a random gap, then hold valid until accepted
    task automatic send_word(input logic [7:0] b);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, WORD_GAP);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_in_byte <= b;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        track_frame_byte(b);
        n_in_words++;
    endtask

    // Drop valid, wait for every owed word, then let the pipeline empty
    task automatic settle_block();
        int waited;
        waited  = 0;
        i_valid <= 1'b0;
        while (out_words_due.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (out_words_due.size() != 0) begin
            $display("%0t: %0d result words never arrived", $time, out_words_due.size());
            n_fail++;
            out_words_due.delete();
        end
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    // Write the payload length limit while the block is idle
    task automatic set_limit(input logic [11:0] value);
        settle_block();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we  <= 1'b0;
        trk_limit = value;
        n_limits++;
    endtask

    // Send a header, then payload and footer only if the length will be taken
    task automatic send_packet(input logic [15:0] proto, input logic [15:0] len);
        send_word(swr_pkg::SYNC_WORD[15:8]);
        send_word(swr_pkg::SYNC_WORD[7:0]);
        send_word(proto[15:8]);
        send_word(proto[7:0]);
        send_word(len[15:8]);
        send_word(len[7:0]);
        if (len <= {4'd0, trk_limit}) begin
            repeat (int'(len) + 2) send_word(8'($urandom_range(0, 255)));
        end
    endtask

    // Feed zero bytes until the tracker hunts for sync again
    task automatic resync_frame();
        while (trk_phase != PH_SYNC_HI) send_word(8'h00);
    endtask

    // Bad sync, forwarded empty packet, button state, oversized header
    task automatic test_directed_frames();
        logic [7:0] seq [0:24];
        seq = '{8'h00, 8'hFF,
                8'hFE, 8'hED, 8'hFF, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h00,
                8'hFE, 8'hED, 8'h00, 8'h08, 8'h00, 8'h01, 8'hA5, 8'h5A, 8'h00,
                8'hFE, 8'hED, 8'h00, 8'h01, 8'h08, 8'h01};
        foreach (seq[i]) send_word(seq[i]);
    endtask

    // Lengths at and just over small limits, far over the reset limit, wrong button sizes included
    task automatic test_payload_limits();
        set_limit(12'd0);
        send_packet(16'h1234, 16'd0);
        send_packet(16'h00FE, 16'd1);
        send_packet(swr_pkg::BUTTON_PROTOCOL, 16'd0);
        set_limit(12'd3);
        send_packet(swr_pkg::BUTTON_PROTOCOL, 16'd3);
        send_packet(16'hED00, 16'd4);
        send_packet(16'h0800, 16'd3);
        set_limit(swr_pkg::MAX_LEN_RESET);
        send_packet(16'h0008, 16'hFFFF);
        send_packet(swr_pkg::BUTTON_PROTOCOL, 16'd1);
    endtask

    // Mostly well-formed packets with random content, some noise and breaks
    task automatic test_random_traffic();
        logic [11:0] limits [0:5];
        logic [15:0] proto;
        logic [15:0] len;
        int          start;
        int          lim;
        int          span;
        int          pick;
        int          sel;
        limits[0] = swr_pkg::MAX_LEN_RESET;
        limits[1] = 12'd0;
        limits[2] = 12'd1;
        limits[3] = 12'($urandom_range(2, 12));
        limits[4] = 12'($urandom_range(0, 2048));
        limits[5] = swr_pkg::MAX_LEN_RESET;
        foreach (limits[p]) begin
            set_limit(limits[p]);
            start = n_in_words;
            while (n_in_words - start < PHASE_WORDS) begin
                tx_steady = ($urandom_range(0, 4) == 0);
                pick      = $urandom_range(0, 19);
                lim       = int'(trk_limit);
                if (pick < 14) begin
                    // well-formed packet
                    if ($urandom_range(0, 2) == 0) begin
                        proto = swr_pkg::BUTTON_PROTOCOL;
                    end else begin
                        proto = 16'($urandom_range(0, 16'hFFFF));
                    end
                    span = ($urandom_range(0, 7) == 0) ? 40 : 8;
                    if (span > lim) span = lim;
                    sel = $urandom_range(0, 9);
                    if (proto == swr_pkg::BUTTON_PROTOCOL && sel < 6 && lim >= 1) begin
                        len = 16'd1;
                    end else if (sel == 8) begin
                        len = 16'(lim + 1 + $urandom_range(0, 2));
                    end else if (sel == 9) begin
                        len = 16'($urandom_range(lim + 1, 16'hFFFF));
                    end else if (sel == 7 && lim <= 40) begin
                        len = 16'(lim);
                    end else begin
                        len = 16'($urandom_range(0, span));
                    end
                    send_packet(proto, len);
                end else if (pick < 17) begin
                    // broken sync or truncated header
                    case ($urandom_range(0, 2))
                        0: begin
                            send_word(swr_pkg::SYNC_WORD[15:8]);
                            sel = $urandom_range(0, 255);
                            if (8'(sel) == swr_pkg::SYNC_WORD[7:0]) sel = sel - 1;
                            send_word(8'(sel));
                        end
                        1: begin
                            send_word(swr_pkg::SYNC_WORD[15:8]);
                            send_word(swr_pkg::SYNC_WORD[7:0]);
                            repeat ($urandom_range(0, 2)) send_word(8'($urandom_range(0, 255)));
                        end
                        default: send_word(swr_pkg::SYNC_WORD[7:0]);
                    endcase
                    resync_frame();
                end else begin
                    // line noise
                    repeat ($urandom_range(1, 4)) send_word(8'($urandom_range(0, 255)));
                    resync_frame();
                end
            end
            tx_steady = 1'b0;
            resync_frame();
        end
    endtask

    // Receive side: stall at random, check each accepted word against the oldest owed
    initial begin
        swr_pkg::t_result due;
        int               stall;
        wait (i_rst_n);
        forever begin
            stall = rx_steady ? 0 : $urandom_range(0, WORD_GAP);
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
            n_out_words++;
            if (out_words_due.size() == 0) begin
                $display("%0t: unexpected result word, expected none, got kind %0d byte %02h last %0d",
                         $time, o_out_kind, o_out_byte, o_last_of_run);
                n_fail++;
            end else begin
                due = out_words_due.pop_front();
                if (due.kind == swr_pkg::KIND_BUTTON) n_button_states++;
                if (o_out_kind !== due.kind) begin
                    $display("%0t: out_kind mismatch, expected %0d, got %0d",
                             $time, due.kind, o_out_kind);
                    n_fail++;
                end
                if (o_out_byte !== due.data) begin
                    $display("%0t: out_byte mismatch, expected %02h, got %02h",
                             $time, due.data, o_out_byte);
                    n_fail++;
                end
                if (o_last_of_run !== due.last) begin
                    $display("%0t: last_of_run mismatch, expected %0d, got %0d",
                             $time, due.last, o_last_of_run);
                    n_fail++;
                end
            end
            if (n_out_words % 40 == 0) rx_steady = ($urandom_range(0, 3) == 0);
        end
    end

    // Main sequence
    initial begin
        trk_phase  = PH_SYNC_HI;
        trk_hold   = 8'h00;
        trk_proto  = 16'h0000;
        trk_len    = 12'd0;
        trk_left   = 12'd0;
        trk_button = 8'h00;
        trk_limit  = swr_pkg::MAX_LEN_RESET;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_frames();
        test_payload_limits();
        test_random_traffic();
        settle_block();
        $display("Covered %0d input bytes and %0d result words (%0d button states)",
                 n_in_words, n_out_words, n_button_states);
        $display("across %0d length limit settings from 0 to 2048, %0d mismatches",
                 n_limits, n_fail);
        if (n_fail == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Watchdog: end a hung run
    initial begin
        #20_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
